// ===== hw/rtl/touch_sample_filter_macros.svh =====
// assertion macros for the touch sample filter checker
`ifndef TOUCH_SAMPLE_FILTER_MACROS_SVH
`define TOUCH_SAMPLE_FILTER_MACROS_SVH

// consequent checked in the same cycle
`define TSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch_sample_filter check failed");

// consequent checked in the next cycle
`define TSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch_sample_filter check failed");

`endif

// ===== hw/rtl/tsf_pkg.sv =====
// shared constants and types for the touch sample filter
package tsf_pkg;

	localparam int SAMPLE_W          = 12;
	localparam int SAMPLES_PER_BATCH = 5;
	localparam int SLOT_W            = $clog2(SAMPLES_PER_BATCH);
	localparam int SUM_W             = SAMPLE_W + 2;
	localparam int SCREEN_W          = 13;
	localparam int TRIES_W           = 8;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT     = 3'd4;

	// register reset values
	localparam logic [SAMPLE_W-1:0] JUMP_LIMIT_RST      = 12'd500;
	localparam logic [SAMPLE_W-1:0] PRESS_THRESHOLD_RST = 12'd30;
	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST    = 13'd800;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST   = 13'd480;
	localparam logic [TRIES_W-1:0]  RETRY_LIMIT_RST     = 8'd100;

	// floor(s / 3) == (s * RECIP3) >> 16 for every sum of three samples
	localparam int RECIP_W  = 15;
	localparam int RECIP_SH = 16;
	localparam logic [RECIP_W-1:0] RECIP3 = 15'd21846;
	localparam int SCALE_SH = 12;

	// ring operations
	localparam logic [1:0] LANE_HOLD   = 2'd0;
	localparam logic [1:0] LANE_BUBBLE = 2'd1;
	localparam logic [1:0] LANE_ROTATE = 2'd2;

	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_idx;
		logic [1:0]        op;
	} lane_ctrl_t;

endpackage

// ===== hw/rtl/touch_sample_filter.sv =====
// touch sample filter top level: batch control, shared multiplier and result register
// Samples are taken one per cycle while the block is idle, into a batch of five. The fifth
// sample of a batch keeps the block busy with bubble passes through the single compare unit
// of each axis ring, then neighbour-step checks, the middle sums and the retry decision, the
// steps on the one shared multiplier (three divides by three, two screen scalings) and the
// load of the result register. A rejected batch returns to sampling after the retry
// decision and produces no result. A pending result does not block sampling; it only
// holds back the end of the next batch until it has been taken.
module touch_sample_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tsf_pkg::SAMPLE_W-1:0]     sample_x,
	input  logic [tsf_pkg::SAMPLE_W-1:0]     sample_y,
	input  logic [tsf_pkg::SAMPLE_W-1:0]     sample_pressure,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             pressed,
	output logic [tsf_pkg::SCREEN_W-1:0]     point_x,
	output logic [tsf_pkg::SAMPLE_W-1:0]     point_y,
	output logic                             press_event,
	output logic                             gave_up
);
	import tsf_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SORT   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_SUM    = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLES_PER_BATCH - 1);
	localparam logic [1:0]        LAST_PASS = 2'(SAMPLES_PER_BATCH - 2);

	// multiplier steps
	localparam logic [SLOT_W-1:0] MUL_AVG_X   = 3'd0;
	localparam logic [SLOT_W-1:0] MUL_AVG_Y   = 3'd1;
	localparam logic [SLOT_W-1:0] MUL_AVG_Z   = 3'd2;
	localparam logic [SLOT_W-1:0] MUL_SCALE_X = 3'd3;
	localparam logic [SLOT_W-1:0] MUL_SCALE_Y = 3'd4;

	localparam int MUL_A_W = SUM_W;
	localparam int MUL_B_W = RECIP_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	logic [2:0]          state_q;
	logic [SLOT_W-1:0]   fill_q;
	logic [SLOT_W-1:0]   step_q;
	logic [1:0]          pass_q;
	logic                unstable_q;
	logic                give_up_q;
	logic [TRIES_W-1:0]  tries_q;
	logic [TRIES_W-1:0]  tries_next;

	logic [SAMPLE_W-1:0] jump_limit_q;
	logic [SAMPLE_W-1:0] press_threshold_q;
	logic [SCREEN_W-1:0] screen_width_q;
	logic [SCREEN_W-1:0] screen_height_q;
	logic [TRIES_W-1:0]  retry_limit_q;

	lane_ctrl_t          lane_ctrl;
	logic                in_fire;
	logic [SAMPLE_W-1:0] gap_x;
	logic [SAMPLE_W-1:0] gap_y;
	logic [SUM_W-1:0]    mid_x;
	logic [SUM_W-1:0]    mid_y;
	logic [SUM_W-1:0]    mid_z;

	logic [SUM_W-1:0]    sum_x_q;
	logic [SUM_W-1:0]    sum_y_q;
	logic [SUM_W-1:0]    sum_z_q;
	logic [SAMPLE_W-1:0] avg_x_q;
	logic [SAMPLE_W-1:0] avg_y_q;
	logic [SAMPLE_W-1:0] avg_z_q;
	logic [SCREEN_W-1:0] scaled_x_q;
	logic [SCREEN_W-1:0] scaled_y_q;

	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   prod;

	logic                out_valid_q;
	logic                pressed_q;
	logic                press_event_q;
	logic                gave_up_q;
	logic [SCREEN_W-1:0] held_x_q;
	logic [SAMPLE_W-1:0] held_y_q;
	logic                was_pressed_q;
	logic                press_now;
	logic [SCREEN_W-1:0] px_now;
	logic [SAMPLE_W-1:0] py_now;
	logic                out_free;

	assign in_ready   = state_q == ST_IDLE;
	assign in_fire    = in_valid && in_ready;
	assign tries_next = tries_q + TRIES_W'(1);

	always_comb begin
		lane_ctrl.wr_en  = in_fire;
		lane_ctrl.wr_idx = fill_q;
		unique case (state_q)
			ST_SORT:  lane_ctrl.op = (step_q == LAST_SLOT) ? LANE_ROTATE : LANE_BUBBLE;
			ST_CHECK: lane_ctrl.op = LANE_ROTATE;
			default:  lane_ctrl.op = LANE_HOLD;
		endcase
	end

	tsf_lane u_lane_x (
		.clk     (clk),
		.ctrl    (lane_ctrl),
		.wr_data (sample_x),
		.gap     (gap_x),
		.mid_sum (mid_x)
	);

	tsf_lane u_lane_y (
		.clk     (clk),
		.ctrl    (lane_ctrl),
		.wr_data (sample_y),
		.gap     (gap_y),
		.mid_sum (mid_y)
	);

	tsf_lane u_lane_z (
		.clk     (clk),
		.ctrl    (lane_ctrl),
		.wr_data (sample_pressure),
		.gap     (),
		.mid_sum (mid_z)
	);

	// shared multiplier
	always_comb begin
		unique case (step_q)
			MUL_AVG_X: begin
				mul_a = sum_x_q;
				mul_b = RECIP3;
			end
			MUL_AVG_Y: begin
				mul_a = sum_y_q;
				mul_b = RECIP3;
			end
			MUL_AVG_Z: begin
				mul_a = sum_z_q;
				mul_b = RECIP3;
			end
			MUL_SCALE_X: begin
				mul_a = MUL_A_W'(avg_x_q);
				mul_b = MUL_B_W'(screen_width_q);
			end
			MUL_SCALE_Y: begin
				mul_a = MUL_A_W'(avg_y_q);
				mul_b = MUL_B_W'(screen_height_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign press_now = avg_z_q >= press_threshold_q;
	assign px_now    = screen_width_q - scaled_x_q;
	assign py_now    = scaled_y_q[SCREEN_W-1] ? '1 : scaled_y_q[SAMPLE_W-1:0];
	assign out_free  = !out_valid_q || out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q      <= JUMP_LIMIT_RST;
			press_threshold_q <= PRESS_THRESHOLD_RST;
			screen_width_q    <= SCREEN_WIDTH_RST;
			screen_height_q   <= SCREEN_HEIGHT_RST;
			retry_limit_q     <= RETRY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_JUMP_LIMIT:      jump_limit_q      <= cfg_data[SAMPLE_W-1:0];
				REG_PRESS_THRESHOLD: press_threshold_q <= cfg_data[SAMPLE_W-1:0];
				REG_SCREEN_WIDTH:    screen_width_q    <= cfg_data[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT:   screen_height_q   <= cfg_data[SCREEN_W-1:0];
				REG_RETRY_LIMIT:     retry_limit_q     <= cfg_data[TRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fill_q        <= '0;
			step_q        <= '0;
			pass_q        <= '0;
			unstable_q    <= 1'b0;
			give_up_q     <= 1'b0;
			tries_q       <= '0;
			out_valid_q   <= 1'b0;
			pressed_q     <= 1'b0;
			press_event_q <= 1'b0;
			gave_up_q     <= 1'b0;
			held_x_q      <= '0;
			held_y_q      <= '0;
			was_pressed_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (fill_q == LAST_SLOT) begin
							fill_q     <= '0;
							step_q     <= '0;
							pass_q     <= '0;
							unstable_q <= 1'b0;
							state_q    <= ST_SORT;
						end else begin
							fill_q <= fill_q + SLOT_W'(1);
						end
					end
				end
				ST_SORT: begin
					if (step_q == LAST_SLOT) begin
						step_q <= '0;
						if (pass_q == LAST_PASS) begin
							state_q <= ST_CHECK;
						end else begin
							pass_q <= pass_q + 2'd1;
						end
					end else begin
						step_q <= step_q + SLOT_W'(1);
					end
				end
				ST_CHECK: begin
					if (step_q == LAST_SLOT) begin
						step_q  <= '0;
						state_q <= ST_SUM;
					end else begin
						if (gap_x > jump_limit_q || gap_y > jump_limit_q) begin
							unstable_q <= 1'b1;
						end
						step_q <= step_q + SLOT_W'(1);
					end
				end
				ST_SUM: begin
					if (unstable_q && tries_next < retry_limit_q) begin
						tries_q <= tries_next;
						state_q <= ST_IDLE;
					end else begin
						tries_q   <= '0;
						give_up_q <= unstable_q;
						step_q    <= MUL_AVG_X;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == MUL_SCALE_Y) begin
						step_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + SLOT_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pressed_q     <= press_now;
						press_event_q <= press_now && !was_pressed_q;
						gave_up_q     <= give_up_q;
						was_pressed_q <= press_now;
						if (press_now) begin
							held_x_q <= px_now;
							held_y_q <= py_now;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			sum_x_q <= mid_x;
			sum_y_q <= mid_y;
			sum_z_q <= mid_z;
		end
		if (state_q == ST_MUL) begin
			unique case (step_q)
				MUL_AVG_X:   avg_x_q    <= prod[RECIP_SH +: SAMPLE_W];
				MUL_AVG_Y:   avg_y_q    <= prod[RECIP_SH +: SAMPLE_W];
				MUL_AVG_Z:   avg_z_q    <= prod[RECIP_SH +: SAMPLE_W];
				MUL_SCALE_X: scaled_x_q <= prod[SCALE_SH +: SCREEN_W];
				MUL_SCALE_Y: scaled_y_q <= prod[SCALE_SH +: SCREEN_W];
				default: begin
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pressed     = pressed_q;
	assign point_x     = held_x_q;
	assign point_y     = held_y_q;
	assign press_event = press_event_q;
	assign gave_up     = gave_up_q;

endmodule

// ===== hw/rtl/tsf_lane.sv =====
// five-entry sample ring of one axis with a single compare-exchange unit
module tsf_lane (
	input  logic                           clk,
	input  tsf_pkg::lane_ctrl_t            ctrl,
	input  logic [tsf_pkg::SAMPLE_W-1:0]   wr_data,
	output logic [tsf_pkg::SAMPLE_W-1:0]   gap,
	output logic [tsf_pkg::SUM_W-1:0]      mid_sum
);
	import tsf_pkg::*;

	logic [SAMPLE_W-1:0] ring_q [SAMPLES_PER_BATCH];
	logic [SAMPLE_W-1:0] hi;
	logic [SAMPLE_W-1:0] lo;
	logic                swap;

	assign swap = ring_q[0] > ring_q[1];
	assign hi   = swap ? ring_q[0] : ring_q[1];
	assign lo   = swap ? ring_q[1] : ring_q[0];

	// on a bubble step the larger value travels on at the head, smaller one drops to the tail
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			ring_q[ctrl.wr_idx] <= wr_data;
		end else begin
			unique case (ctrl.op)
				LANE_BUBBLE: begin
					ring_q[0] <= hi;
					for (int i = 1; i < SAMPLES_PER_BATCH - 1; i++) begin
						ring_q[i] <= ring_q[i+1];
					end
					ring_q[SAMPLES_PER_BATCH-1] <= lo;
				end
				LANE_ROTATE: begin
					for (int i = 0; i < SAMPLES_PER_BATCH - 1; i++) begin
						ring_q[i] <= ring_q[i+1];
					end
					ring_q[SAMPLES_PER_BATCH-1] <= ring_q[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign gap     = ring_q[1] - ring_q[0];
	assign mid_sum = SUM_W'(ring_q[1]) + SUM_W'(ring_q[2]) + SUM_W'(ring_q[3]);

endmodule

// ===== hw/rtl/tsf_checker.sv =====
// port-level checker for the touch sample filter, bound to the top level
`include "touch_sample_filter_macros.svh"

module tsf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             pressed,
	input logic [tsf_pkg::SCREEN_W-1:0]     point_x,
	input logic [tsf_pkg::SAMPLE_W-1:0]     point_y,
	input logic                             press_event
);

	// a stalled result holds
	`TSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(pressed) && $stable(point_x) && $stable(point_y))

	// a press edge is only reported on a pressed result
	`TSF_ASSERT_NOW(a_event_pressed, out_valid && press_event, pressed)

	// a fresh result follows a busy cycle
	`TSF_ASSERT_NOW(a_result_after_busy, $rose(out_valid), !$past(in_ready))

	// held coordinates only move together with a new result
	`TSF_ASSERT_NOW(a_point_moves_with_result,
		!$stable(point_x) || !$stable(point_y), out_valid)

endmodule

bind touch_sample_filter tsf_checker u_tsf_checker (.*);
